// ===== hdl/irfs_pkg.sv =====
// Shared types and constants of the infrared frame serializer.
// Used by the top level, the input queue, the engine and the result queue; depends on nothing.
package irfs_pkg;

	localparam int FRAME_W   = 12;
	localparam int PERIOD_W  = 16;
	localparam int REFILL_W  = 21;
	localparam int TIMER_W   = 32;
	localparam int CREDIT_W  = 8;
	localparam int BITS_W    = 4;
	localparam int WAIT_W    = 7;
	localparam int BURST_W   = 4;
	localparam int PULSE_W   = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 21;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_PUSH = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_PERIOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_REFILL  = 2'd2;

	localparam logic [PULSE_W-1:0]  BURST_PULSES     = 3'd7;
	localparam logic [WAIT_W-1:0]   HALF_BIT_TICKS   = 7'd13;
	localparam logic [WAIT_W-1:0]   BIT_TICKS        = 7'd27;
	localparam logic [WAIT_W-1:0]   LAST_BIT_TICKS   = 7'd70;
	localparam logic [BURST_W-1:0]  BURST_DELAY      = 4'd13;
	localparam logic [BITS_W-1:0]   LAST_START_COUNT = 4'd11;
	localparam logic [BITS_W-1:0]   FRAME_BIT_COUNT  = 4'd15;
	localparam logic [CREDIT_W-1:0] MAX_CREDITS      = 8'd4;
	localparam logic [CREDIT_W-1:0] FAST_CREDITS     = 8'd128;
	localparam logic [7:0]          CHAR_EOT         = 8'd4;
	localparam logic [7:0]          CHAR_LF          = 8'd10;

	localparam logic [PERIOD_W-1:0] DEF_PULSE_PERIOD = 16'd255;
	localparam logic [REFILL_W-1:0] DEF_LINE_REFILL  = 21'd65536;

	typedef struct packed {
		logic               command;
		logic [FRAME_W-1:0] frame_word;
	} item_t;

	typedef struct packed {
		logic                carrier_on;
		logic [PERIOD_W-1:0] pwm_compare;
		logic                push_accepted;
		logic                transmitting;
	} result_t;

endpackage

// ===== hdl/ir_frame_serializer_with_line_pacing_top.sv =====
// Top level of the infrared frame serializer with line pacing.
// Instantiates irfs_in_q, irfs_engine and irfs_out_q; depends on irfs_pkg.
//
// Every item (a frame push or a carrier-period tick) gives exactly one result. Items
// enter through a two-entry input queue, the engine executes one item per clock cycle,
// and results wait in a two-entry output queue, so one item per cycle is sustained
// while results are popped each cycle; a result is registered in the output queue when
// the engine takes its item, and the queue head drives the result ports. The engine
// settles the whole state of an item combinationally: up to four line credit refills,
// carrier compare, serializer step and the frame ring queue, whose head is kept in a
// register read ahead of use. Configuration is always ready.
module ir_frame_serializer_with_line_pacing_top #(
	parameter int QUEUE_DEPTH = 16,
	localparam int LEVEL_W    = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic                            command,
	input  logic [irfs_pkg::FRAME_W-1:0]    frame_word,
	output logic                            empty,
	input  logic                            pop,
	output logic                            carrier_on,
	output logic [irfs_pkg::PERIOD_W-1:0]   pwm_compare,
	output logic                            push_accepted,
	output logic [LEVEL_W-1:0]              queue_level,
	output logic                            transmitting,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [irfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [irfs_pkg::CFG_DAT_W-1:0]  cfg_data
);

	irfs_pkg::item_t    item;
	logic               item_valid;
	logic               item_take;
	irfs_pkg::result_t  res;
	logic [LEVEL_W-1:0] res_level;
	logic               res_wr;
	logic               res_full;
	irfs_pkg::result_t  head;

	irfs_in_q u_in_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.frame_word (frame_word),
		.item       (item),
		.item_valid (item_valid),
		.item_take  (item_take)
	);

	irfs_engine #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.LEVEL_W     (LEVEL_W)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item       (item),
		.item_valid (item_valid),
		.item_take  (item_take),
		.res        (res),
		.res_level  (res_level),
		.res_wr     (res_wr),
		.res_full   (res_full)
	);

	irfs_out_q #(
		.LEVEL_W (LEVEL_W)
	) u_out_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_wr     (res_wr),
		.res        (res),
		.res_level  (res_level),
		.res_full   (res_full),
		.empty      (empty),
		.pop        (pop),
		.head       (head),
		.head_level (queue_level)
	);

	assign carrier_on    = head.carrier_on;
	assign pwm_compare   = head.pwm_compare;
	assign push_accepted = head.push_accepted;
	assign transmitting  = head.transmitting;

endmodule

// ===== hdl/irfs_in_q.sv =====
// Front end: two-entry queue that takes push and tick items from the input side.
// Depends on irfs_pkg.
module irfs_in_q (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          command,
	input  logic [irfs_pkg::FRAME_W-1:0]  frame_word,
	output irfs_pkg::item_t               item,
	output logic                          item_valid,
	input  logic                          item_take
);

	irfs_pkg::item_t slot_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            wr_en;

	assign full       = (count_q == 2'd2);
	assign item_valid = (count_q != 2'd0);
	assign item       = slot_q[rd_ptr_q];
	assign wr_en      = push && !full;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= '{command: command, frame_word: frame_word};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (item_take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({wr_en, item_take})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/irfs_engine.sv =====
// Back end: configuration registers, frame ring queue, line credits, carrier and serializer.
// Executes one item per cycle while the result queue is not full; depends on irfs_pkg.
module irfs_engine #(
	parameter int QUEUE_DEPTH = 16,
	parameter int LEVEL_W     = 5
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [irfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [irfs_pkg::CFG_DAT_W-1:0]  cfg_data,
	input  irfs_pkg::item_t                 item,
	input  logic                            item_valid,
	output logic                            item_take,
	output irfs_pkg::result_t               res,
	output logic [LEVEL_W-1:0]              res_level,
	output logic                            res_wr,
	input  logic                            res_full
);

	localparam int                 PTR_W     = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0]   LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [LEVEL_W-1:0] DEPTH_LVL = LEVEL_W'(QUEUE_DEPTH);
	localparam int                 MULT_W    = irfs_pkg::REFILL_W + 2;

	logic                              slow_mode_q;
	logic [irfs_pkg::PERIOD_W-1:0]     period_q;
	logic [irfs_pkg::REFILL_W-1:0]     refill_q;

	logic [irfs_pkg::FRAME_W-1:0]      queue_mem [QUEUE_DEPTH];
	logic [irfs_pkg::FRAME_W-1:0]      head_q;
	logic [PTR_W-1:0]                  rd_ptr_q, rd_ptr_d;
	logic [PTR_W-1:0]                  wr_ptr_q, wr_ptr_d;
	logic [LEVEL_W-1:0]                level_q, level_d;
	logic [irfs_pkg::FRAME_W-1:0]      cur_q, cur_d;
	logic [irfs_pkg::BITS_W-1:0]       bits_q, bits_d;
	logic [irfs_pkg::WAIT_W-1:0]       bit_wait_q, bit_wait_d;
	logic [irfs_pkg::BURST_W-1:0]      burst_q, burst_d;
	logic [irfs_pkg::PULSE_W-1:0]      pulses_q, pulses_d;
	logic [irfs_pkg::CREDIT_W-1:0]     credits_q, credits_d;
	logic [irfs_pkg::TIMER_W-1:0]      timer_q, timer_d;

	logic                              go;
	logic                              do_write;
	logic                              res_on;
	logic [irfs_pkg::PERIOD_W-1:0]     res_cmp;
	logic                              res_acc;

	logic [irfs_pkg::TIMER_W-1:0]      timer_inc;
	logic [MULT_W-1:0]                 mult1, mult2, mult3, mult4, mult_sel;
	logic [2:0]                        fit_cnt;
	logic [2:0]                        need;
	logic [2:0]                        refills;
	logic [irfs_pkg::CREDIT_W-1:0]     credits_u;
	logic [irfs_pkg::TIMER_W-1:0]      timer_u;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == LAST_PTR) ? '0 : p + 1'b1;
	endfunction

	assign cfg_ready = 1'b1;
	assign go        = item_valid && !res_full;
	assign item_take = go;
	assign res_wr    = go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_mode_q <= 1'b0;
			period_q    <= irfs_pkg::DEF_PULSE_PERIOD;
			refill_q    <= irfs_pkg::DEF_LINE_REFILL;
		end else if (cfg_valid) begin
			case (cfg_index)
				irfs_pkg::CFG_SLOW_MODE:    slow_mode_q <= cfg_data[0];
				irfs_pkg::CFG_PULSE_PERIOD: period_q    <= cfg_data[irfs_pkg::PERIOD_W-1:0];
				irfs_pkg::CFG_LINE_REFILL:  refill_q    <= cfg_data[irfs_pkg::REFILL_W-1:0];
				default:                    slow_mode_q <= slow_mode_q;
			endcase
		end
	end

	// line credit refill in slow mode, settled in one step; fast mode sets the credits to FAST_CREDITS
	always_comb begin
		timer_inc = (&timer_q) ? timer_q : timer_q + 1'b1;
		mult1     = MULT_W'(refill_q);
		mult2     = {1'b0, refill_q, 1'b0};
		mult3     = mult1 + mult2;
		mult4     = {refill_q, 2'b00};
		fit_cnt   = 3'(timer_q >= irfs_pkg::TIMER_W'(mult1))
		          + 3'(timer_q >= irfs_pkg::TIMER_W'(mult2))
		          + 3'(timer_q >= irfs_pkg::TIMER_W'(mult3))
		          + 3'(timer_q >= irfs_pkg::TIMER_W'(mult4));
		need      = (credits_q < irfs_pkg::MAX_CREDITS)
		          ? 3'(irfs_pkg::MAX_CREDITS - credits_q) : 3'd0;
		refills   = (fit_cnt < need) ? fit_cnt : need;
		case (refills)
			3'd1:    mult_sel = mult1;
			3'd2:    mult_sel = mult2;
			3'd3:    mult_sel = mult3;
			3'd4:    mult_sel = mult4;
			default: mult_sel = '0;
		endcase
		if (slow_mode_q) begin
			timer_u   = timer_inc - irfs_pkg::TIMER_W'(mult_sel);
			credits_u = credits_q + irfs_pkg::CREDIT_W'(refills);
		end else begin
			timer_u   = timer_inc;
			credits_u = irfs_pkg::FAST_CREDITS;
		end
	end

	always_comb begin
		rd_ptr_d   = rd_ptr_q;
		wr_ptr_d   = wr_ptr_q;
		level_d    = level_q;
		cur_d      = cur_q;
		bits_d     = bits_q;
		bit_wait_d = bit_wait_q;
		burst_d    = burst_q;
		pulses_d   = pulses_q;
		credits_d  = credits_q;
		timer_d    = timer_q;
		do_write   = 1'b0;
		res_on     = 1'b0;
		res_cmp    = '0;
		res_acc    = 1'b0;
		if (go) begin
			if (item.command == irfs_pkg::CMD_PUSH) begin
				if (level_q < DEPTH_LVL) begin
					do_write = 1'b1;
					wr_ptr_d = ptr_inc(wr_ptr_q);
					level_d  = level_q + 1'b1;
					res_acc  = 1'b1;
				end
			end else begin
				credits_d = credits_u;
				timer_d   = timer_u;
				if (pulses_q == '0) begin
					res_cmp = (&period_q) ? period_q : period_q + 1'b1;
				end else begin
					res_on   = 1'b1;
					res_cmp  = period_q >> 1;
					pulses_d = pulses_q - 1'b1;
				end
				if (bit_wait_q == '0) begin
					if (bits_q == '0) begin
						if (credits_u != '0 && cur_q == '0 && level_q != '0) begin
							cur_d    = head_q;
							rd_ptr_d = ptr_inc(rd_ptr_q);
							level_d  = level_q - 1'b1;
							if (head_q != '0) begin
								if (head_q[7:0] == irfs_pkg::CHAR_EOT
								    || head_q[7:0] == irfs_pkg::CHAR_LF) begin
									credits_d = credits_u - 1'b1;
								end
								bits_d = irfs_pkg::FRAME_BIT_COUNT;
							end
						end
					end else begin
						bits_d = bits_q - 1'b1;
						if (bits_d > irfs_pkg::LAST_START_COUNT) begin
							bit_wait_d = irfs_pkg::HALF_BIT_TICKS;
							pulses_d   = irfs_pkg::BURST_PULSES;
						end else begin
							bit_wait_d = irfs_pkg::BIT_TICKS;
							if (cur_q[bits_d]) begin
								pulses_d = irfs_pkg::BURST_PULSES;
							end else begin
								burst_d = irfs_pkg::BURST_DELAY;
							end
							if (bits_d == '0) begin
								bit_wait_d = irfs_pkg::LAST_BIT_TICKS;
								cur_d      = '0;
							end
						end
					end
				end else begin
					bit_wait_d = bit_wait_q - 1'b1;
				end
				if (burst_d != '0) begin
					burst_d = burst_d - 1'b1;
					if (burst_d == '0) begin
						pulses_d = irfs_pkg::BURST_PULSES;
					end
				end
			end
		end
	end

	assign res.carrier_on    = res_on;
	assign res.pwm_compare   = res_cmp;
	assign res.push_accepted = res_acc;
	assign res.transmitting  = (bits_d != '0) || (pulses_d != '0) || (burst_d != '0);
	assign res_level         = level_d;

	// hold the oldest frame in a register; bypass a write to the slot being read
	always_ff @(posedge clk) begin
		if (do_write) begin
			queue_mem[wr_ptr_q] <= item.frame_word;
		end
		if (do_write && wr_ptr_q == rd_ptr_d) begin
			head_q <= item.frame_word;
		end else begin
			head_q <= queue_mem[rd_ptr_d];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
			level_q    <= '0;
			cur_q      <= '0;
			bits_q     <= '0;
			bit_wait_q <= '0;
			burst_q    <= '0;
			pulses_q   <= '0;
			credits_q  <= irfs_pkg::MAX_CREDITS;
			timer_q    <= '0;
		end else begin
			rd_ptr_q   <= rd_ptr_d;
			wr_ptr_q   <= wr_ptr_d;
			level_q    <= level_d;
			cur_q      <= cur_d;
			bits_q     <= bits_d;
			bit_wait_q <= bit_wait_d;
			burst_q    <= burst_d;
			pulses_q   <= pulses_d;
			credits_q  <= credits_d;
			timer_q    <= timer_d;
		end
	end

`ifndef SYNTHESIS
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= DEPTH_LVL)
		else $error("frame queue level beyond depth");

	a_frame_has_bits: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q != '0 |-> bits_q != '0)
		else $error("frame held with no bits left");

	a_push_level: assert property (@(posedge clk) disable iff (!arst_n)
		go && item.command == irfs_pkg::CMD_PUSH && level_q < DEPTH_LVL
		|=> level_q == $past(level_q) + 1'b1)
		else $error("stored frame not counted");

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credits_q <= irfs_pkg::FAST_CREDITS)
		else $error("line credits out of range");
`endif

endmodule

// ===== hdl/irfs_out_q.sv =====
// Result side: two-entry queue that holds finished results until popped.
// Depends on irfs_pkg.
module irfs_out_q #(
	parameter int LEVEL_W = 5
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    res_wr,
	input  irfs_pkg::result_t       res,
	input  logic [LEVEL_W-1:0]      res_level,
	output logic                    res_full,
	output logic                    empty,
	input  logic                    pop,
	output irfs_pkg::result_t       head,
	output logic [LEVEL_W-1:0]      head_level
);

	irfs_pkg::result_t  slot_q  [2];
	logic [LEVEL_W-1:0] level_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic               rd_en;

	assign res_full   = (count_q == 2'd2);
	assign empty      = (count_q == 2'd0);
	assign rd_en      = pop && !empty;
	assign head       = slot_q[rd_ptr_q];
	assign head_level = level_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (res_wr) begin
			slot_q[wr_ptr_q]  <= res;
			level_q[wr_ptr_q] <= res_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (res_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({res_wr, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
